// File: rtl/rrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg
// shared types and constants of the range reservation checker
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int FUNC_BITS   = 1;
    localparam int SLOT_BITS   = 10;
    localparam int AMOUNT_BITS = 30;
    localparam int COUNT_BITS  = 24;
    localparam int S_DATA_BITS = 56;
    localparam int M_DATA_BITS = 32;

    localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_BITS-1:0] FUNC_RESERVE = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_CHK_RD  = 7'b0000100,
        ST_CHK_CMP = 7'b0001000,
        ST_UPD_RD  = 7'b0010000,
        ST_UPD_WR  = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic write_load;
        logic count_req;
        logic addr_first;
        logic addr_inc;
        logic read_slot;
        logic write_sub;
        logic set_fail;
        logic grant_set;
        logic grant_clr;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic failed;
        logic range_empty;
        logic at_last;
        logic slot_short;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/rrc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_ctrl
// sequencer: decode, check scan over the range, update scan, result hand-off
// ----------------------------------------------------------------------------
module rrc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rrc_pkg::sts_t sts,
    output rrc_pkg::cmd_t cmd
);
    import rrc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.grant_clr = 1'b1;
                if (sts.is_load) begin
                    cmd.write_load = 1'b1;
                    state_next     = ST_FINISH;
                end else if (sts.failed) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.count_req = 1'b1;
                    if (sts.range_empty) begin
                        cmd.grant_clr = 1'b0;
                        cmd.grant_set = 1'b1;
                        state_next    = ST_FINISH;
                    end else begin
                        cmd.addr_first = 1'b1;
                        state_next     = ST_CHK_RD;
                    end
                end
            end
            ST_CHK_RD: begin
                cmd.read_slot = 1'b1;
                state_next    = ST_CHK_CMP;
            end
            ST_CHK_CMP: begin
                if (sts.slot_short) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_FINISH;
                end else if (sts.at_last) begin
                    cmd.addr_first = 1'b1;
                    state_next     = ST_UPD_RD;
                end else begin
                    cmd.addr_inc = 1'b1;
                    state_next   = ST_CHK_RD;
                end
            end
            ST_UPD_RD: begin
                cmd.read_slot = 1'b1;
                state_next    = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                cmd.write_sub = 1'b1;
                if (sts.at_last) begin
                    cmd.grant_set = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.addr_inc = 1'b1;
                    state_next   = ST_UPD_RD;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rrc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_datapath
// slot memory, scan address, failure bookkeeping and result register
// ----------------------------------------------------------------------------
module rrc_datapath #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rrc_pkg::S_DATA_BITS-1:0] s_tdata,
    input  rrc_pkg::cmd_t                   cmd,
    output rrc_pkg::sts_t                   sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rrc_pkg::M_DATA_BITS-1:0] m_tdata
);
    import rrc_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = ((AW > SLOT_BITS) ? AW : SLOT_BITS) + 1;
    localparam int WW = ((VALUE_BITS > AMOUNT_BITS) ? VALUE_BITS : AMOUNT_BITS) + 1;
    localparam logic [IW-1:0] SLOTS_I = IW'(SLOTS);
    localparam logic [WW-1:0] VMAX_W  = WW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

    logic [VALUE_BITS-1:0] mem [SLOTS];
    logic [VALUE_BITS-1:0] rdata_reg;

    logic [FUNC_BITS-1:0]   func_reg;
    logic [IW-1:0]          lo_reg;
    logic [IW-1:0]          hi_reg;
    logic [AMOUNT_BITS-1:0] amt_reg;
    logic [AW-1:0]          addr_reg;
    logic                   failed_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  fail_num_reg;
    logic                   grant_reg;
    logic                   valid_reg;
    logic                   out_grant_reg;
    logic                   out_failed_reg;
    logic [COUNT_BITS-1:0]  out_num_reg;

    logic [IW-1:0] hi_clip;
    logic [WW-1:0] amt_w;
    logic [WW-1:0] rdata_w;
    logic [WW-1:0] load_w;
    logic [WW-1:0] diff_w;

    assign amt_w   = WW'(amt_reg);
    assign rdata_w = WW'(rdata_reg);
    assign load_w  = (amt_w > VMAX_W) ? VMAX_W : amt_w;
    assign diff_w  = rdata_w - amt_w;
    assign hi_clip = (hi_reg >= SLOTS_I) ? (SLOTS_I - IW'(1)) : hi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_tdata[0 +: FUNC_BITS];
            lo_reg   <= IW'(s_tdata[FUNC_BITS +: SLOT_BITS]);
            hi_reg   <= IW'(s_tdata[FUNC_BITS + SLOT_BITS +: SLOT_BITS]);
            amt_reg  <= s_tdata[FUNC_BITS + 2 * SLOT_BITS +: AMOUNT_BITS];
        end
        if (cmd.addr_first) begin
            addr_reg <= lo_reg[AW-1:0];
        end else if (cmd.addr_inc) begin
            addr_reg <= addr_reg + AW'(1);
        end
    end

    // slot memory: one read or one write per cycle
    always_ff @(posedge aclk) begin
        if (cmd.write_load && (lo_reg < SLOTS_I)) begin
            mem[lo_reg[AW-1:0]] <= load_w[VALUE_BITS-1:0];
        end else if (cmd.write_sub) begin
            mem[addr_reg] <= diff_w[VALUE_BITS-1:0];
        end
        if (cmd.read_slot) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failed_reg   <= 1'b0;
            count_reg    <= '0;
            fail_num_reg <= '0;
            grant_reg    <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (cmd.count_req && (count_reg != COUNT_MAX)) begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.set_fail) begin
                failed_reg   <= 1'b1;
                fail_num_reg <= count_reg;
            end
            if (cmd.grant_set) begin
                grant_reg <= 1'b1;
            end else if (cmd.grant_clr) begin
                grant_reg <= 1'b0;
            end
            if (cmd.push) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_grant_reg  <= grant_reg;
            out_failed_reg <= failed_reg;
            out_num_reg    <= fail_num_reg;
        end
    end

    assign sts.is_load     = (func_reg == FUNC_LOAD);
    assign sts.failed      = failed_reg;
    assign sts.range_empty = (lo_reg >= SLOTS_I) || (lo_reg > hi_clip);
    assign sts.at_last     = (IW'(addr_reg) == hi_clip);
    assign sts.slot_short  = (rdata_w < amt_w);
    assign sts.out_free    = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - 2 - COUNT_BITS){1'b0}},
                       out_num_reg, out_failed_reg, out_grant_reg};

    a_fail_num_set: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> (fail_num_reg != '0))
        else $error("failure recorded without request number");

    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> (failed_reg && $stable(fail_num_reg)))
        else $error("failure record changed after first failure");

    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> $stable(count_reg))
        else $error("request counter moved after failure");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && valid_reg) |-> m_tready)
        else $error("result overwritten while still held");

endmodule

// File: rtl/range_reservation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_reservation_checker
// remaining-capacity store with range reservations and sticky failure record
// ----------------------------------------------------------------------------
// usage: s_ channel carries load and reserve items, m_ channel returns one
// result item for every input item, in order.
// a load writes its first slot, then its result goes to the output register.
// a reserve item walks its clipped range twice over the single-port slot
// memory, first to check every slot, then to subtract; a refused one stops at
// the first short slot. none walks after a recorded failure or an empty range.
// one item is in work at a time; the sequencer returns to idle before the next.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next item is taken while it waits. if
// m_tready stays low, the following result waits in the sequencer and
// s_tready stays low.
// reset clears the failure flag, request counter and output valid; slot
// contents are not cleared and every slot must be loaded before use.
// ----------------------------------------------------------------------------
module range_reservation_checker #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func, first_slot, last_slot, amount
    input  logic [rrc_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // granted, failed_sticky, fail_request_number
    output logic [rrc_pkg::M_DATA_BITS-1:0] m_tdata
);
    import rrc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrc_datapath #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
